@@ sv/lsmc_pkg.sv @@
// Shared types and constants of the LIFO stack with match count.
package lsmc_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_COUNT = 2'b10
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

@@ sv/lsmc_cell.sv @@
// One stack cell: holds a word, shifts on push and pop, adds its match to a count chain.
module lsmc_cell import lsmc_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic [WordW-1:0]        up_word_i,
  input  logic [WordW-1:0]        down_word_i,
  input  logic [WordW-1:0]        key_i,
  input  logic [CntW-1:0]         occ_i,
  input  logic [CntW-1:0]         cnt_i,
  output logic [WordW-1:0]        word_o,
  output logic [CntW-1:0]         cnt_o
);

  logic [WordW-1:0] word_q, word_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             hit;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.push) begin
      word_d = up_word_i;
    end else if (ctrl_i.pop) begin
      word_d = down_word_i;
    end
  end

  // only entries below the occupancy take part
  assign hit   = (CntW'(Idx) < occ_i) && (word_q == key_i);
  assign cnt_d = cnt_i + CntW'(hit);

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cnt_q  <= cnt_d;
  end

  assign word_o = word_q;
  assign cnt_o  = cnt_q;

endmodule

@@ sv/lifo_stack_with_match_count_unit.sv @@
// LIFO stack of signed words with a match count, built as a shifting row of cells.
//
// The top of the stack sits in the first cell; a push shifts every word one cell down and a
// pop shifts them one cell up. For push, pop and clear, start is taken with busy
// low and the result beat appears on done_o in the next cycle, and a new command may follow
// at once. A count runs a registered partial sum along the row of DEPTH cells, so it holds
// busy high until the sum has run the length of the row, and then gives its result beat.
// Each result beat is on the ports for exactly one cycle and must be taken then.
module lifo_stack_with_match_count_unit import lsmc_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic signed [WordW-1:0]      value_i,
  output logic                         done_o,
  output logic signed [WordW-1:0]      result_word_o,
  output logic signed [WordW-1:0]      top_word_o,
  output logic                         is_empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy_o,
  output logic [1:0]                   error_o
);

  localparam int unsigned CntW = $clog2(DEPTH+1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   occ_q, occ_d;
  logic [CntW-1:0]   wait_q, wait_d;
  logic [WordW-1:0]  key_q, key_d;
  logic              done_q, done_d;
  logic [WordW-1:0]  res_q, res_d, top_q, top_d;
  logic              empty_q, empty_d;
  logic [CntW-1:0]   occ_out_q, occ_out_d;
  logic [1:0]        err_q, err_d;

  logic [WordW-1:0]  words [DEPTH];
  logic [CntW-1:0]   cnts  [DEPTH];
  cell_ctrl_t        ctrl;
  logic              accept;
  op_e               op;
  logic              full, empty;

  assign accept = start && (state_q == ST_IDLE);
  assign op     = op_e'(operation_i);
  assign full   = (occ_q == CntW'(DEPTH));
  assign empty  = (occ_q == '0);

  always_comb begin
    ctrl.push = accept && (op == OP_PUSH) && !full;
    ctrl.pop  = accept && (op == OP_POP) && !empty;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] up_w, down_w;
    logic [CntW-1:0]  cnt_in;
    if (i == 0) begin : g_first
      assign up_w   = value_i;
      assign cnt_in = '0;
    end else begin : g_mid
      assign up_w   = words[i-1];
      assign cnt_in = cnts[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign down_w = words[i];
    end else begin : g_inner
      assign down_w = words[i+1];
    end
    lsmc_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .up_word_i   (up_w),
      .down_word_i (down_w),
      .key_i       (key_q),
      .occ_i       (occ_q),
      .cnt_i       (cnt_in),
      .word_o      (words[i]),
      .cnt_o       (cnts[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    wait_d    = wait_q;
    key_d     = key_q;
    done_d    = 1'b0;
    res_d     = res_q;
    top_d     = top_q;
    empty_d   = empty_q;
    occ_out_d = occ_out_q;
    err_d     = err_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          err_d = ERR_NONE;
          case (op)
            OP_PUSH: begin
              if (full) begin
                err_d = ERR_PUSH_FULL;
              end else begin
                occ_d = occ_q + 1'b1;
              end
            end
            OP_POP: begin
              if (empty) begin
                err_d = ERR_POP_EMPTY;
              end else begin
                occ_d = occ_q - 1'b1;
                res_d = words[0];
              end
            end
            OP_CLEAR: begin
              occ_d = '0;
            end
            default: begin
              key_d = value_i;
            end
          endcase
          if (op == OP_COUNT) begin
            wait_d  = '0;
            state_d = ST_COUNT;
          end else begin
            done_d    = 1'b1;
            occ_out_d = occ_d;
            empty_d   = (occ_d == '0);
            if (occ_d == '0) begin
              top_d = '0;
            end else if (ctrl.push) begin
              top_d = value_i;
            end else if (ctrl.pop) begin
              top_d = words[1];
            end else begin
              top_d = words[0];
            end
          end
        end
      end
      ST_COUNT: begin
        // hold until the partial sum has run the length of the row
        wait_d = wait_q + 1'b1;
        if (wait_q == CntW'(DEPTH)) begin
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          res_d     = empty ? '1 : WordW'(cnts[DEPTH-1]);
          top_d     = empty ? '0 : words[0];
          empty_d   = empty;
          occ_out_d = occ_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      wait_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      wait_q  <= wait_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    res_q     <= res_d;
    top_q     <= top_d;
    empty_q   <= empty_d;
    occ_out_q <= occ_out_d;
    err_q     <= err_d;
  end

  assign busy          = (state_q == ST_COUNT);
  assign done_o        = done_q;
  assign result_word_o = res_q;
  assign top_word_o    = top_q;
  assign is_empty_o    = empty_q;
  assign occupancy_o   = occ_out_q;
  assign error_o       = err_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(DEPTH))
    else $error("stack occupancy beyond depth");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (occupancy_o == '0)))
    else $error("empty flag disagrees with occupancy");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(occ_q))
    else $error("occupancy moved during a count");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (error_o != ERR_NONE)) |-> (result_word_o == '0))
    else $error("error beat carries a non-zero word");
`endif

endmodule

@@ dv/testbench.sv @@
// Testbench for the LIFO stack with match count: directed and random commands against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsmc_pkg::*;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned OccW     = $clog2(DEPTH + 1);
  localparam int unsigned NumItems = 1100;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct {
    op_e         op;
    word_t       word;
    int unsigned gap;
    bit          drain;
  } stack_cmd_t;

  typedef struct {
    word_t           res_word;
    word_t           top_word;
    logic            is_empty;
    logic [OccW-1:0] occupancy;
    err_e            err;
  } stack_beat_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  logic [1:0]      operation_i = OP_PUSH;
  word_t           value_i     = '0;
  logic            done_o;
  word_t           result_word_o;
  word_t           top_word_o;
  logic            is_empty_o;
  logic [OccW-1:0] occupancy_o;
  logic [1:0]      error_o;

  stack_cmd_t  cmd_q[$];
  stack_beat_t beat_q[$];
  word_t       model_store [DEPTH];
  int unsigned model_count = 0;
  int unsigned n_fail      = 0;
  int unsigned n_queued    = 0;
  bit          gaps_on     = 1'b1;
  word_t       key_pool [4];

  lifo_stack_with_match_count_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .result_word_o(result_word_o),
    .top_word_o   (top_word_o),
    .is_empty_o   (is_empty_o),
    .occupancy_o  (occupancy_o),
    .error_o      (error_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Apply one command to the shadow stack and return the beat it should produce.
  function automatic stack_beat_t apply_stack_op(op_e op, word_t word);
    stack_beat_t b;
    int unsigned n;
    b.res_word = '0;
    b.err      = ERR_NONE;
    n          = 0;
    case (op)
      OP_PUSH: begin
        if (model_count >= DEPTH) begin
          b.err = ERR_PUSH_FULL;
        end else begin
          model_store[model_count] = word;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          b.err = ERR_POP_EMPTY;
        end else begin
          model_count--;
          b.res_word = model_store[model_count];
        end
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: begin
        if (model_count == 0) begin
          b.res_word = -1;
        end else begin
          for (int unsigned i = 0; i < model_count; i++) begin
            if (model_store[i] == word) n++;
          end
          b.res_word = word_t'(n);
        end
      end
    endcase
    b.top_word  = (model_count == 0) ? '0 : model_store[model_count - 1];
    b.is_empty  = (model_count == 0);
    b.occupancy = OccW'(model_count);
    return b;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic word_t pick_word();
    if ($urandom_range(0, 9) < 4) return key_pool[$urandom_range(0, 3)];
    return word_t'($urandom);
  endfunction

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_PUSH;
    if (r < 75) return OP_POP;
    if (r < 95) return OP_COUNT;
    return OP_CLEAR;
  endfunction

  function automatic void add_cmd(op_e op, word_t word, bit drain = 1'b0);
    stack_cmd_t c;
    c.op    = op;
    c.word  = word;
    c.gap   = pick_gap();
    c.drain = drain;
    cmd_q.push_back(c);
    n_queued++;
  endfunction

  // Driver: a beat is taken when start is high and busy is low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        beat_q.push_back(apply_stack_op(op_e'(operation_i), value_i));
      end
      if (!start || !busy) begin
        if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_q[0].gap != 0) begin
          cmd_q[0].gap = cmd_q[0].gap - 1;
          start <= 1'b0;
        end else if (cmd_q[0].drain && beat_q.size() != 0) begin
          // hold until every outstanding result has come back
          start <= 1'b0;
        end else begin
          start       <= 1'b1;
          operation_i <= cmd_q[0].op;
          value_i     <= cmd_q[0].word;
          void'(cmd_q.pop_front());
        end
      end
    end
  end

  // Monitor: every result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    stack_beat_t want;
    if (rst_ni && done_o) begin
      if (beat_q.size() == 0) begin
        $error("unexpected result beat: result_word %0d", result_word_o);
        n_fail++;
      end else begin
        want = beat_q.pop_front();
        if (result_word_o !== want.res_word) begin
          $error("result_word: expected %0d, got %0d", want.res_word, result_word_o);
          n_fail++;
        end
        if (top_word_o !== want.top_word) begin
          $error("top_word: expected %0d, got %0d", want.top_word, top_word_o);
          n_fail++;
        end
        if (is_empty_o !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty_o);
          n_fail++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          n_fail++;
        end
        if (error_o !== want.err) begin
          $error("error: expected %0d, got %0d", want.err, error_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned seg;
    int unsigned len;
    int unsigned kind;

    // directed: empty-stack cases, word extremes, duplicates, clear and reuse
    add_cmd(OP_COUNT, '0);
    add_cmd(OP_POP, word_t'(32'h1234_5678));
    add_cmd(OP_CLEAR, '0);
    add_cmd(OP_PUSH, word_t'(32'h7fff_ffff));
    add_cmd(OP_PUSH, word_t'(32'h8000_0000));
    add_cmd(OP_PUSH, word_t'(32'hffff_ffff));
    add_cmd(OP_PUSH, '0);
    add_cmd(OP_PUSH, word_t'(32'h8000_0000));
    add_cmd(OP_COUNT, word_t'(32'h8000_0000));
    add_cmd(OP_COUNT, word_t'(32'h7fff_ffff));
    add_cmd(OP_COUNT, word_t'(32'h0000_0001));
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, word_t'(32'hffff_ffff));
    add_cmd(OP_CLEAR, word_t'(32'hffff_ffff));
    add_cmd(OP_COUNT, word_t'(32'hffff_ffff));
    add_cmd(OP_POP, '0);
    add_cmd(OP_PUSH, word_t'(32'ha5a5_a5a5));
    add_cmd(OP_PUSH, word_t'(32'h5a5a_5a5a));
    add_cmd(OP_COUNT, word_t'(32'ha5a5_a5a5));
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, '0, 1'b1);

    // random: fill, drain, mixed and noise runs; the first run always overfills
    seg = 0;
    while (n_queued < NumItems) begin
      gaps_on     = ($urandom_range(0, 3) != 0);
      key_pool[0] = ($urandom_range(0, 1) != 0) ? word_t'(32'h8000_0000)
                                                : word_t'(32'h7fff_ffff);
      key_pool[1] = ($urandom_range(0, 1) != 0) ? word_t'(0) : word_t'(-1);
      key_pool[2] = word_t'($urandom);
      key_pool[3] = word_t'($urandom);
      kind = (seg == 0) ? 0 : $urandom_range(0, 3);
      case (kind)
        0: begin
          len = DEPTH + $urandom_range(1, 6);
          for (int unsigned i = 0; i < len; i++) begin
            if (seg != 0 && $urandom_range(0, 9) == 0) add_cmd(OP_COUNT, pick_word());
            else add_cmd(OP_PUSH, pick_word());
          end
        end
        1: begin
          len = $urandom_range(10, 70);
          for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 6) == 0) add_cmd(OP_COUNT, pick_word());
            else add_cmd(OP_POP, word_t'($urandom));
          end
        end
        2: begin
          len = $urandom_range(20, 60);
          for (int unsigned i = 0; i < len; i++) add_cmd(pick_op(), pick_word());
        end
        default: begin
          len = $urandom_range(5, 15);
          for (int unsigned i = 0; i < len; i++) begin
            add_cmd(op_e'($urandom_range(0, 3)), word_t'($urandom));
          end
        end
      endcase
      if ($urandom_range(0, 5) == 0) add_cmd(pick_op(), pick_word(), 1'b1);
      seg++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start || beat_q.size() != 0) @(posedge clk_i);
    // let a late or stray beat show up before the verdict
    repeat (DEPTH + 8) @(posedge clk_i);

    if (n_fail == 0 && beat_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lsmc_pkg.sv
sv/lsmc_cell.sv
sv/lifo_stack_with_match_count_unit.sv
dv/testbench.sv
